@@ sv/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared codes, field widths and rule constants for the life grid step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int CMD_W = 2;
    localparam int ROW_W = 5;
    localparam int COL_W = 5;
    localparam int OUT_W = 32;

    // neighbour count: 0..8
    localparam int CNT_W = 4;

    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [CNT_W-1:0] BIRTH_COUNT  = 4'd3;
    localparam logic [CNT_W-1:0] SURVIVE_LOW  = 4'd2;
    localparam logic [CNT_W-1:0] SURVIVE_HIGH = 4'd3;

    typedef logic [CNT_W-1:0] nbr_cnt_t;

endpackage

@@ sv/life_grid_generation_step_top.sv @@
// ----------------------------------------------------------------------------
// life_grid_generation_step_top
// Bit grid of cells with set, read-row and B3/S23 generation-step commands.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | word
//  ----------+-------------------------+-----------------------------------
//  command   | start & !busy accepts   | command, row, col
//  result    | done, one cycle, no hold| row_cells (zero unless a read)
//
//  An ignored command (bad row/col or unused code) never leaves idle; it
//  only raises the result strobe, which is registered. The advance is bound
//  by the row sweep: one row read and one row written back per cycle
//  through the grid RAM. Reset clears the per-row valid bits at once (no
//  clearing pass): a row never written since reset reads as all dead. The
//  receiver cannot stall; busy stays high only while a command is at work.
//
module life_grid_generation_step_top #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lgs_pkg::CMD_W-1:0]       command,
    input  logic [lgs_pkg::ROW_W-1:0]       row,
    input  logic [lgs_pkg::COL_W-1:0]       col,
    output logic                            done,
    output logic [lgs_pkg::OUT_W-1:0]       row_cells
);

    localparam int AW = $clog2(GRID_ROWS);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SET_WR = 3'd1;  // OR the new cell into the row read
    localparam logic [2:0] ST_RD_OUT = 3'd2;  // row data back from RAM
    localparam logic [2:0] ST_FILL   = 3'd3;  // row 0 arrives, row 1 requested
    localparam logic [2:0] ST_RUN    = 3'd4;  // one row out per cycle

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;      // set target / sweep row
    logic [GRID_COLS-1:0] mask_reg, mask_next;
    logic [GRID_COLS-1:0] prev_reg, prev_next;      // old row r-1
    logic [GRID_COLS-1:0] cur_reg, cur_next;        // old row r
    logic [GRID_ROWS-1:0] vld_reg, vld_next;
    logic                 rd_vld_reg;
    logic                 done_reg, done_next;
    logic [lgs_pkg::OUT_W-1:0] cells_reg, cells_next;

    // RAM port signals
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [GRID_COLS-1:0] ram_wdata, ram_q, q_data;

    logic                 accept;
    logic [8:0]           row_ext;
    logic [6:0]           col_ext;
    logic                 row_ok, col_ok;
    logic [AW-1:0]        in_addr;
    logic [GRID_COLS-1:0] in_mask;
    logic [AW:0]          ahead;                     // sweep row + 2
    logic                 last_row;
    logic [GRID_COLS-1:0] below_row, new_row;
    logic [lgs_pkg::OUT_W-1:0] rd_word;

    assign accept  = start & (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign row_cells = cells_reg;

    assign row_ext = {4'b0, row};
    assign col_ext = {2'b0, col};
    assign row_ok  = (row_ext < 9'(GRID_ROWS));
    assign col_ok  = (col_ext < 7'(GRID_COLS));
    assign in_addr = row_ext[AW-1:0];
    assign in_mask = {{(GRID_COLS-1){1'b0}}, 1'b1} << col;

    // rows never written since reset read as dead
    assign q_data = ram_q & {GRID_COLS{rd_vld_reg}};

    assign ahead    = {1'b0, addr_reg} + (AW+1)'(2);
    assign last_row = (addr_reg == AW'(GRID_ROWS-1));
    assign below_row = last_row ? '0 : q_data;

    // only columns 0..31 are visible on the result
    generate
        if (GRID_COLS >= lgs_pkg::OUT_W)
        begin : g_wide
            assign rd_word = q_data[lgs_pkg::OUT_W-1:0];
        end
        else
        begin : g_narrow
            assign rd_word = {{(lgs_pkg::OUT_W-GRID_COLS){1'b0}}, q_data};
        end
    endgenerate

    lgs_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    lgs_row_rule #(
        .COLS (GRID_COLS)
    ) u_row_rule (
        .above    (prev_reg),
        .center   (cur_reg),
        .below    (below_row),
        .next_row (new_row)
    );

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        mask_next  = mask_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        vld_next   = vld_reg;
        done_next  = 1'b0;
        cells_next = '0;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = new_row;
        ram_re     = 1'b0;
        ram_raddr  = in_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = in_addr;
                    mask_next = in_mask;
                    case (command)
                        lgs_pkg::CMD_SET:
                        begin
                            if (row_ok && col_ok)
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_SET_WR;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        lgs_pkg::CMD_READ:
                        begin
                            if (row_ok)
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_RD_OUT;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        lgs_pkg::CMD_STEP:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            addr_next  = '0;
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SET_WR:
            begin
                ram_we             = 1'b1;
                ram_wdata          = q_data | mask_reg;
                vld_next[addr_reg] = 1'b1;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_RD_OUT:
            begin
                done_next  = 1'b1;
                cells_next = rd_word;
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                // grid has at least three rows, so row 1 exists
                ram_re     = 1'b1;
                ram_raddr  = AW'(1);
                prev_next  = '0;
                cur_next   = q_data;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // q_data is old row r+1; writes stay behind the read pointer
                ram_we             = 1'b1;
                vld_next[addr_reg] = 1'b1;
                prev_next          = cur_reg;
                cur_next           = q_data;
                if (ahead < (AW+1)'(GRID_ROWS))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ahead[AW-1:0];
                end
                if (last_row)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            done_reg  <= done_next;
            if (ram_re)
            begin
                rd_vld_reg <= vld_reg[ram_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        mask_reg  <= mask_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        cells_reg <= cells_next;
    end

endmodule

@@ sv/lgs_ram.sv @@
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/lgs_row_rule.sv @@
// ----------------------------------------------------------------------------
// lgs_row_rule
// Next-generation bits of one row from a three-row window (B3/S23, no wrap).
// ----------------------------------------------------------------------------
module lgs_row_rule #(
    parameter int COLS = 32
) (
    input  logic [COLS-1:0] above,
    input  logic [COLS-1:0] center,
    input  logic [COLS-1:0] below,
    output logic [COLS-1:0] next_row
);

    // bit c of *_w holds column c-1, bit c of *_e holds column c+1; edges read 0
    logic [COLS-1:0] above_w, above_e, center_w, center_e, below_w, below_e;

    assign above_w  = above  << 1;
    assign above_e  = above  >> 1;
    assign center_w = center << 1;
    assign center_e = center >> 1;
    assign below_w  = below  << 1;
    assign below_e  = below  >> 1;

    always_comb
    begin
        lgs_pkg::nbr_cnt_t n;
        n = '0;
        next_row = '0;
        for (int c = 0; c < COLS; c++)
        begin
            n = lgs_pkg::nbr_cnt_t'(above_w[c]) + lgs_pkg::nbr_cnt_t'(above[c])
              + lgs_pkg::nbr_cnt_t'(above_e[c]) + lgs_pkg::nbr_cnt_t'(center_w[c])
              + lgs_pkg::nbr_cnt_t'(center_e[c]) + lgs_pkg::nbr_cnt_t'(below_w[c])
              + lgs_pkg::nbr_cnt_t'(below[c]) + lgs_pkg::nbr_cnt_t'(below_e[c]);
            if (center[c])
            begin
                next_row[c] = n inside {[lgs_pkg::SURVIVE_LOW:lgs_pkg::SURVIVE_HIGH]};
            end
            else
            begin
                next_row[c] = (n == lgs_pkg::BIRTH_COUNT);
            end
        end
    end

endmodule

@@ tb/life_grid_step_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_step_checker
// Watches the command and result channels of the life grid step block,
// keeps its own copy of the cell grid and checks every result word.
// ----------------------------------------------------------------------------
module life_grid_step_checker #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [lgs_pkg::CMD_W-1:0] command,
    input  logic [lgs_pkg::ROW_W-1:0] row,
    input  logic [lgs_pkg::COL_W-1:0] col,
    input  logic                      done,
    input  logic [lgs_pkg::OUT_W-1:0] row_cells,
    output int                        fail_count,
    output int                        pending
);

    localparam int CMD_W = lgs_pkg::CMD_W;
    localparam int ROW_W = lgs_pkg::ROW_W;
    localparam int OUT_W = lgs_pkg::OUT_W;

    typedef struct {
        int               seq;
        logic [CMD_W-1:0] cmd;
        logic [ROW_W-1:0] r;
        logic [OUT_W-1:0] cells;
    } row_word_t;

    logic [GRID_COLS-1:0] grid [GRID_ROWS];
    row_word_t            expected_rows [$];
    int                   errors;
    int                   accepted;

    assign fail_count = errors;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // out-of-grid cells count as dead
    function automatic bit cell_alive(input int r, input int c);
        if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS)
            return 1'b0;
        return grid[r][c];
    endfunction

    function automatic void advance_generation();
        logic [GRID_COLS-1:0] next_grid [GRID_ROWS];
        int                   nbrs;
        bit                   alive;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            for (int c = 0; c < GRID_COLS; c++)
            begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            nbrs += cell_alive(r + dr, c + dc);
                alive = cell_alive(r, c);
                next_grid[r][c] = alive ? (nbrs >= lgs_pkg::SURVIVE_LOW &&
                                           nbrs <= lgs_pkg::SURVIVE_HIGH)
                                        : (nbrs == lgs_pkg::BIRTH_COUNT);
            end
        end
        grid = next_grid;
    endfunction

    // applies one command word to the grid copy, returns the expected row word
    function automatic logic [OUT_W-1:0] apply_command(input logic [CMD_W-1:0] cmd,
                                                       input int r, input int c);
        logic [OUT_W-1:0] word;
        word = '0;
        case (cmd)
            lgs_pkg::CMD_SET:  if (r < GRID_ROWS && c < GRID_COLS) grid[r][c] = 1'b1;
            lgs_pkg::CMD_STEP: advance_generation();
            lgs_pkg::CMD_READ: if (r < GRID_ROWS) word = OUT_W'(grid[r]);
            default:           ;
        endcase
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        row_word_t exp_word;
        row_word_t new_word;
        if (!rst_n)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
                grid[r] = '0;
            expected_rows.delete();
            accepted = 0;
            errors   = 0;
            pending <= 0;
        end
        else
        begin
            // results first: a word accepted at this edge answers at a later one
            if (done)
            begin
                if (expected_rows.size() == 0)
                begin
                    report_error($sformatf("result %08h with no command outstanding",
                                           row_cells));
                end
                else
                begin
                    exp_word = expected_rows.pop_front();
                    if (row_cells !== exp_word.cells)
                        report_error($sformatf(
                            "word %0d cmd %0d row %0d: row_cells %08h, expected %08h",
                            exp_word.seq, exp_word.cmd, exp_word.r, row_cells,
                            exp_word.cells));
                end
            end
            if (start && !busy)
            begin
                new_word.seq   = accepted;
                new_word.cmd   = command;
                new_word.r     = row;
                new_word.cells = apply_command(command, int'(row), int'(col));
                expected_rows.push_back(new_word);
                accepted++;
            end
            pending <= expected_rows.size();
        end
    end

endmodule

@@ tb/life_grid_generation_step_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_step_top_tb
// Drives set, advance, read and unused command words into the life grid
// block; the checker beside it predicts every row word and counts mismatches.
// ----------------------------------------------------------------------------
module life_grid_generation_step_top_tb;

    localparam int GRID_ROWS = 32;
    localparam int GRID_COLS = 32;

    localparam int CMD_W = lgs_pkg::CMD_W;
    localparam int ROW_W = lgs_pkg::ROW_W;
    localparam int COL_W = lgs_pkg::COL_W;
    localparam int OUT_W = lgs_pkg::OUT_W;

    // code the block leaves unused: no effect, zero result
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam int WORD_TARGET    = 1350;
    // longest quiet stretch: an advance plus a sender idle run
    localparam int WATCHDOG_LIMIT = 2000;
    // drain time after the last result, a bit over one advance
    localparam int DRAIN_CYCLES   = GRID_ROWS + 10;

    logic             clk;
    logic             rst_n   = 1'b0;
    logic             start   = 1'b0;
    logic             busy;
    logic [CMD_W-1:0] command = lgs_pkg::CMD_SET;
    logic [ROW_W-1:0] row     = '0;
    logic [COL_W-1:0] col     = '0;
    logic             done;
    logic [OUT_W-1:0] row_cells;

    int fail_count;
    int pending;
    int words_sent  = 0;
    int quiet_count = 0;

    // starts low so the first rising edge is a clean 0 -> 1
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    life_grid_generation_step_top #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .row       (row),
        .col       (col),
        .done      (done),
        .row_cells (row_cells)
    );

    life_grid_step_checker #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .row        (row),
        .col        (col),
        .done       (done),
        .row_cells  (row_cells),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: any accepted command word or result strobe resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_count <= 0;
        end
        else if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Sender idle rate per phase: 19% first third, 61% second, none at the end.
    function automatic int idle_percent();
        if (words_sent < WORD_TARGET / 3)
            return 19;
        if (words_sent < 2 * WORD_TARGET / 3)
            return 61;
        return 0;
    endfunction

    // Present one word and hold it until the block takes it. Called at a
    // rising edge. Each cycle before the word idles with the phase's chance;
    // start is only dropped for such idle cycles, so back-to-back words keep
    // it high without a low/high pair in one time step.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input int r, input int c);
        if ($urandom_range(0, 99) < idle_percent())
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_percent());
        end
        start   <= 1'b1;
        command <= cmd;
        row     <= ROW_W'(r);
        col     <= COL_W'(c);
        // busy read here is the pre-edge value, same as the block samples
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    task automatic set_cell(input int r, input int c);
        send_word(lgs_pkg::CMD_SET, r, c);
    endtask

    task automatic read_row(input int r);
        send_word(lgs_pkg::CMD_READ, r, $urandom_range(0, 31));
    endtask

    task automatic advance_grid();
        send_word(lgs_pkg::CMD_STEP, $urandom_range(0, 31), $urandom_range(0, 31));
    endtask

    // Seed a glider, a blinker or a scatter of cells near (r0, c0). Offsets
    // that run past row/col 31 wrap in the field width, which just scatters them.
    task automatic seed_pattern(input int r0, input int c0);
        case ($urandom_range(0, 2))
            0:
            begin
                set_cell(r0, c0 + 1);
                set_cell(r0 + 1, c0 + 2);
                set_cell(r0 + 2, c0);
                set_cell(r0 + 2, c0 + 1);
                set_cell(r0 + 2, c0 + 2);
            end
            1:
            begin
                for (int k = 0; k < 3; k++)
                    set_cell(r0, c0 + k);
            end
            default:
            begin
                repeat ($urandom_range(1, 12))
                    set_cell(r0 + $urandom_range(0, 3), c0 + $urandom_range(0, 3));
            end
        endcase
    endtask

    initial
    begin
        int r0;
        int c0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // grid is dead after reset
        read_row(0);
        // 2x2 block in the top-left corner: survives at the edge
        set_cell(0, 0);
        set_cell(0, 1);
        set_cell(1, 0);
        set_cell(1, 1);
        // lone cell in the far corner: dies
        set_cell(31, 31);
        // vertical blinker against the right edge: flips to a clipped row
        set_cell(0, 31);
        set_cell(1, 31);
        set_cell(2, 31);
        // free blinker in the middle
        set_cell(10, 5);
        set_cell(10, 6);
        set_cell(10, 7);
        // unused code with every field bit set: no change, zero word
        send_word(CMD_NOP, 31, 31);
        read_row(0);
        advance_grid();
        read_row(0);
        read_row(1);
        read_row(2);
        read_row(9);
        read_row(10);
        read_row(11);
        read_row(31);
        advance_grid();
        read_row(10);

        // ---------------- random part ----------------
        while (words_sent < WORD_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    // seed at rows that share r0's two low bits, evolve, then read rows r0 to r0+4
                    r0 = $urandom_range(0, 31);
                    c0 = $urandom_range(0, 31);
                    repeat ($urandom_range(1, 3))
                        seed_pattern($urandom_range(0, 31) & ~3 | (r0 & 3), c0);
                    repeat ($urandom_range(0, 3))
                        advance_grid();
                    repeat ($urandom_range(1, 6))
                        read_row(r0 + $urandom_range(0, 4));
                end
                6, 7:
                begin
                    // noise: any code, any fields
                    send_word(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                              $urandom_range(0, 31));
                end
                default:
                begin
                    // full readback, sometimes right after an advance
                    if ($urandom_range(0, 1) == 1)
                        advance_grid();
                    for (int r = 0; r < GRID_ROWS; r++)
                        read_row(r);
                end
            endcase
        end

        // ---------------- drain and verdict ----------------
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
